// ===== rtl/tcon_pkg.sv =====
// Shared types and constants for the text console block.
// Used by tcon_ctrl, tcon_dp and text_console_with_ansi_escapes_unit.
`default_nettype none
package tcon_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Width of the cell index fields on the ports
  localparam int POS_W = 11;

  // Reset values
  localparam logic [7:0]  COLOUR_RESET = 8'h02;
  localparam logic [15:0] BLANK_CELL   = 16'h0f20;

  // Byte codes
  localparam logic [7:0] CHAR_ESC      = 8'h1b;
  localparam logic [7:0] CHAR_LBRACKET = 8'h5b;
  localparam logic [7:0] CHAR_D        = 8'h44;
  localparam logic [7:0] CHAR_C        = 8'h43;
  localparam logic [7:0] CHAR_K        = 8'h4b;
  localparam logic [7:0] CHAR_J        = 8'h4a;
  localparam logic [7:0] CHAR_NL       = 8'h0a;
  localparam logic [7:0] CHAR_CR       = 8'h0d;
  localparam logic [7:0] CHAR_BS       = 8'h08;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;

  // Escape arguments that act
  localparam logic [3:0] CSI_ERASE_LINE   = 4'd2;
  localparam logic [3:0] CSI_ERASE_SCREEN = 4'd3;

  // Item modes
  localparam logic MODE_FEED = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [7:0]       char_code;
    logic [POS_W-1:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       cell_char;
    logic [7:0]       cell_attribute;
    logic [POS_W-1:0] cursor_position;
    logic             swallowed;
  } out_item_t;

  // Work that follows the decode cycle
  typedef enum logic [1:0] {
    FOLLOW_NONE,
    FOLLOW_READ,
    FOLLOW_FILL,
    FOLLOW_SCROLL
  } follow_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic capture_read;
    logic fill_step;
    logic copy_step;
    logic scroll_tail;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    follow_t follow;
    logic    sweep_last;
    logic    out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

// ===== rtl/tcon_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module tcon_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/tcon_ctrl.sv =====
// Controller state machine of the text console: sequences decode, reads and sweeps.
// Depends on tcon_pkg.
`default_nettype none
module tcon_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tcon_pkg::ctrl_sts_t sts,
  output tcon_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_FILL,
    ST_COPY,
    ST_COPY_TAIL,
    ST_FIN
  } state_t;

  state_t state;
  state_t state_next;

  // Commands to the datapath
  always_comb begin
    cmd              = '0;
    cmd.capture      = (state == ST_IDLE) && in_valid;
    cmd.exec         = (state == ST_EXEC);
    cmd.capture_read = (state == ST_RD_WAIT);
    cmd.fill_step    = (state == ST_FILL) || (state == ST_INIT);
    cmd.copy_step    = (state == ST_COPY);
    cmd.scroll_tail  = (state == ST_COPY_TAIL);
    cmd.finish       = (state == ST_FIN) && sts.out_free;
  end

  assign in_stall = (state != ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sts.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (sts.follow)
          tcon_pkg::FOLLOW_READ:   state_next = ST_RD_WAIT;
          tcon_pkg::FOLLOW_FILL:   state_next = ST_FILL;
          tcon_pkg::FOLLOW_SCROLL: state_next = ST_COPY;
          default:                 state_next = ST_FIN;
        endcase
      end
      ST_RD_WAIT: state_next = ST_FIN;
      ST_FILL: begin
        if (sts.sweep_last) state_next = ST_FIN;
      end
      ST_COPY: begin
        if (sts.sweep_last) state_next = ST_COPY_TAIL;
      end
      ST_COPY_TAIL: state_next = ST_FILL;
      ST_FIN: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tcon_dp.sv =====
// Datapath of the text console: cursor, escape parser, screen RAM and output register.
// Depends on tcon_pkg and tcon_ram.
`default_nettype none
module tcon_dp #(
  parameter int COLUMNS = tcon_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcon_pkg::DEF_ROWS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tcon_pkg::ctrl_cmd_t  cmd,
  output tcon_pkg::ctrl_sts_t       sts,
  input  wire tcon_pkg::in_item_t   in_item,
  input  wire logic                 cfg_wen,
  input  wire logic [7:0]           cfg_wdata,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tcon_pkg::out_item_t       out_item
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int PW    = (CW > tcon_pkg::POS_W) ? CW : tcon_pkg::POS_W;
  localparam int SW    = CLW + 4;

  localparam logic [CW-1:0]  CELLS_C  = CW'(CELLS);
  localparam logic [CW-1:0]  COLS_C   = CW'(COLUMNS);
  localparam logic [CW-1:0]  COPY_END = CW'((ROWS - 1) * COLUMNS);
  localparam logic [CLW-1:0] COL_MAX  = CLW'(COLUMNS - 1);
  localparam logic [RW-1:0]  ROW_MAX  = RW'(ROWS - 1);

  tcon_pkg::in_item_t item;
  logic [CLW-1:0] col;
  logic [RW-1:0]  row;
  logic           esc_seen;
  logic           csi_act;
  logic [3:0]     csi_num;
  logic [7:0]     colour;
  logic [CW-1:0]  sweep;
  logic [CW-1:0]  sweep_end;
  logic           copy_pend;
  logic [AW-1:0]  copy_waddr;
  logic [7:0]     rd_char;
  logic [7:0]     rd_attr;
  logic           sw_flag;

  logic [CLW-1:0] col_next;
  logic [RW-1:0]  row_next;
  logic           esc_seen_next;
  logic           csi_act_next;
  logic [3:0]     csi_num_next;
  logic           sw_next;
  logic           prn_we;
  logic [CW-1:0]  fill_start;
  logic [CW-1:0]  fill_end;
  tcon_pkg::follow_t follow;

  logic [CW-1:0]  line_start;
  logic [CW-1:0]  cur_pos;
  logic [SW-1:0]  col_sum;
  logic [RW:0]    row_w;
  logic [7:0]     c;
  logic [CW-1:0]  copy_raddr;
  logic [PW-1:0]  rd_addr_ext;
  logic [PW-1:0]  cursor_ext;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [15:0]    ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [15:0]    ram_rdata;

  assign c           = item.char_code;
  assign line_start  = CW'(row) * COLS_C;
  assign cur_pos     = line_start + CW'(col);
  assign col_sum     = SW'(col) + SW'(csi_num);
  assign copy_raddr  = sweep + COLS_C;
  assign rd_addr_ext = PW'(item.cell_address);
  assign cursor_ext  = PW'(cur_pos);

  // Decode one item: escape parser, cursor moves and follow-up work
  always_comb begin
    col_next      = col;
    row_next      = row;
    esc_seen_next = esc_seen;
    csi_act_next  = csi_act;
    csi_num_next  = csi_num;
    sw_next       = 1'b0;
    prn_we        = 1'b0;
    fill_start    = line_start;
    fill_end      = line_start + COLS_C;
    follow        = tcon_pkg::FOLLOW_NONE;
    row_w         = {1'b0, row};
    if (item.mode == tcon_pkg::MODE_READ) begin
      if (rd_addr_ext < PW'(CELLS)) begin
        follow = tcon_pkg::FOLLOW_READ;
      end
    end else if (csi_act) begin
      sw_next = 1'b1;
      if (c >= tcon_pkg::CHAR_ZERO && c <= tcon_pkg::CHAR_NINE) begin
        csi_num_next = c[3:0];
      end else begin
        case (c)
          tcon_pkg::CHAR_D: begin
            if (SW'(csi_num) > SW'(col)) begin
              col_next = '0;
            end else begin
              col_next = CLW'(SW'(col) - SW'(csi_num));
            end
          end
          tcon_pkg::CHAR_C: begin
            if (col_sum > SW'(COLUMNS - 1)) begin
              col_next = COL_MAX;
            end else begin
              col_next = col_sum[CLW-1:0];
            end
          end
          tcon_pkg::CHAR_K: begin
            if (csi_num == tcon_pkg::CSI_ERASE_LINE) begin
              follow = tcon_pkg::FOLLOW_FILL;
            end
          end
          tcon_pkg::CHAR_J: begin
            if (csi_num == tcon_pkg::CSI_ERASE_SCREEN) begin
              follow     = tcon_pkg::FOLLOW_FILL;
              fill_start = '0;
              fill_end   = CELLS_C;
              col_next   = '0;
              row_next   = '0;
            end
          end
          default: ;
        endcase
        csi_num_next = '0;
        csi_act_next = 1'b0;
      end
    end else if (esc_seen && c == tcon_pkg::CHAR_LBRACKET) begin
      sw_next       = 1'b1;
      csi_act_next  = 1'b1;
      esc_seen_next = 1'b0;
    end else if (c == tcon_pkg::CHAR_ESC) begin
      sw_next       = 1'b1;
      esc_seen_next = 1'b1;
    end else begin
      case (c)
        tcon_pkg::CHAR_NL: begin
          col_next = '0;
          row_w    = row_w + 1'b1;
        end
        tcon_pkg::CHAR_CR: begin
          col_next = '0;
        end
        tcon_pkg::CHAR_BS: begin
          if (col != '0) begin
            col_next = col - 1'b1;
          end else begin
            col_next = COL_MAX;
            if (row != '0) row_w = row_w - 1'b1;
          end
        end
        default: begin
          prn_we = 1'b1;
          if (col == COL_MAX) begin
            col_next = '0;
            row_w    = row_w + 1'b1;
          end else begin
            col_next = col + 1'b1;
          end
        end
      endcase
      // Scroll when the cursor drops below the last row
      if (row_w > (RW + 1)'(ROWS - 1)) begin
        row_next   = ROW_MAX;
        col_next   = '0;
        follow     = tcon_pkg::FOLLOW_SCROLL;
        fill_start = '0;
        fill_end   = COPY_END;
      end else begin
        row_next = row_w[RW-1:0];
      end
    end
  end

  // Screen RAM ports: pending copy write, then blank fill, then print
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_pos[AW-1:0];
    ram_wdata = {colour, c};
    if (copy_pend) begin
      ram_we    = 1'b1;
      ram_waddr = copy_waddr;
      ram_wdata = ram_rdata;
    end else if (cmd.fill_step) begin
      ram_we    = 1'b1;
      ram_waddr = sweep[AW-1:0];
      ram_wdata = tcon_pkg::BLANK_CELL;
    end else if (cmd.exec && prn_we) begin
      ram_we = 1'b1;
    end
    if (cmd.copy_step) begin
      ram_raddr = copy_raddr[AW-1:0];
    end else begin
      ram_raddr = rd_addr_ext[AW-1:0];
    end
  end

  tcon_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status to the controller
  always_comb begin
    sts            = '0;
    sts.follow     = follow;
    sts.sweep_last = (sweep == sweep_end - 1'b1);
    sts.out_free   = !out_valid || !out_stall;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      esc_seen  <= 1'b0;
      csi_act   <= 1'b0;
      csi_num   <= '0;
      colour    <= tcon_pkg::COLOUR_RESET;
      sweep     <= '0;
      sweep_end <= CELLS_C;
      copy_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) colour <= cfg_wdata;
      if (cmd.exec) begin
        col       <= col_next;
        row       <= row_next;
        esc_seen  <= esc_seen_next;
        csi_act   <= csi_act_next;
        csi_num   <= csi_num_next;
        sweep     <= fill_start;
        sweep_end <= fill_end;
      end
      if (cmd.fill_step || cmd.copy_step) sweep <= sweep + 1'b1;
      if (cmd.scroll_tail) begin
        sweep     <= COPY_END;
        sweep_end <= CELLS_C;
      end
      copy_pend <= cmd.copy_step;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.finish) out_valid <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) item <= in_item;
    if (cmd.copy_step) copy_waddr <= sweep[AW-1:0];
    if (cmd.exec) begin
      sw_flag <= sw_next;
      rd_char <= '0;
      rd_attr <= '0;
    end
    if (cmd.capture_read) begin
      rd_char <= ram_rdata[7:0];
      rd_attr <= ram_rdata[15:8];
    end
    if (cmd.finish) begin
      out_item.cell_char       <= rd_char;
      out_item.cell_attribute  <= rd_attr;
      out_item.cursor_position <= cursor_ext[tcon_pkg::POS_W-1:0];
      out_item.swallowed       <= sw_flag;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/text_console_with_ansi_escapes_unit.sv =====
// Top level of the text console: controller plus datapath.
// Depends on tcon_pkg, tcon_ctrl, tcon_dp and tcon_ram.
//
// Usage:
//   Input transactions (in_valid / in_stall / in_item) carry one item: in mode 0 a
//   character byte for the console, in mode 1 a cell index to read back.
//   Output transactions (out_valid / out_stall / out_item) return one result per
//   item: the read cell (zero in mode 0), the cursor index and the swallowed flag.
//   cfg_wen / cfg_wdata write the attribute stored with each printed character.
//   Throughput: one item is in flight at a time. Erase line, erase screen and a scroll
//   take longer than an ordinary byte or a read, since the screen RAM moves one cell per
//   cycle through its single write port.
//   After reset all ROWS*COLUMNS cells (2000 by default) are swept to blanks with
//   in_stall high; cfg writes are taken during the sweep.
//   A result waits in the output register while out_stall is high; the next item
//   is still accepted and processed, and its result waits until the slot frees.
`default_nettype none
module text_console_with_ansi_escapes_unit #(
  parameter int COLUMNS = tcon_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcon_pkg::DEF_ROWS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tcon_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tcon_pkg::out_item_t     out_item,
  input  wire logic               cfg_wen,
  input  wire logic [7:0]         cfg_wdata
);

  tcon_pkg::ctrl_cmd_t cmd;
  tcon_pkg::ctrl_sts_t sts;

  tcon_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcon_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== dv/text_console_with_ansi_escapes_unit_tb.sv =====
// Testbench for the text console unit: drives console bytes and cell reads, predicts
// each result from a behavioral screen model and compares field by field.
// Depends on tcon_pkg and text_console_with_ansi_escapes_unit.
`timescale 1ns / 1ps
module text_console_with_ansi_escapes_unit_tb;

  localparam int COLS  = tcon_pkg::DEF_COLUMNS;
  localparam int LINES = tcon_pkg::DEF_ROWS;
  localparam int CELLS = COLS * LINES;
  localparam int POS_W = tcon_pkg::POS_W;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  tcon_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tcon_pkg::out_item_t out_item;
  logic cfg_wen = 1'b0;
  logic [7:0] cfg_wdata = '0;

  text_console_with_ansi_escapes_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the console state
  logic [15:0] shadow_screen [CELLS];
  int unsigned cur_col, cur_row;
  bit esc_pending, csi_open;
  logic [3:0] csi_arg;
  logic [7:0] shadow_colour;

  tcon_pkg::in_item_t  pending_items [$];
  tcon_pkg::out_item_t expected_results [$];
  int errors = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void blank_row(input int unsigned r);
    for (int i = 0; i < COLS; i++) shadow_screen[r * COLS + i] = tcon_pkg::BLANK_CELL;
  endfunction

  task automatic console_reset();
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = tcon_pkg::BLANK_CELL;
    cur_col = 0; cur_row = 0;
    esc_pending = 0; csi_open = 0; csi_arg = '0;
    shadow_colour = tcon_pkg::COLOUR_RESET;
  endtask

  // Returns 1 when the escape parser consumes the byte
  function automatic bit parse_escape(input logic [7:0] c);
    if (csi_open) begin
      if (c >= tcon_pkg::CHAR_ZERO && c <= tcon_pkg::CHAR_NINE) begin
        csi_arg = 4'(c - tcon_pkg::CHAR_ZERO);
        return 1;
      end
      if (c == tcon_pkg::CHAR_D) begin
        cur_col = (csi_arg > cur_col) ? 0 : cur_col - csi_arg;
      end else if (c == tcon_pkg::CHAR_C) begin
        cur_col = cur_col + csi_arg;
        if (cur_col > COLS - 1) cur_col = COLS - 1;
      end else if (c == tcon_pkg::CHAR_K) begin
        if (csi_arg == tcon_pkg::CSI_ERASE_LINE) blank_row(cur_row);
      end else if (c == tcon_pkg::CHAR_J) begin
        if (csi_arg == tcon_pkg::CSI_ERASE_SCREEN) begin
          for (int r = 0; r < LINES; r++) blank_row(r);
          cur_col = 0; cur_row = 0;
        end
      end
      csi_arg = '0;
      csi_open = 0;
      return 1;
    end
    if (esc_pending && c == tcon_pkg::CHAR_LBRACKET) begin
      csi_open = 1; esc_pending = 0;
      return 1;
    end
    if (c == tcon_pkg::CHAR_ESC) begin
      esc_pending = 1;
      return 1;
    end
    return 0;
  endfunction

  function automatic void print_byte(input logic [7:0] c);
    if (c == tcon_pkg::CHAR_NL) begin
      cur_col = 0; cur_row++;
    end else if (c == tcon_pkg::CHAR_CR) begin
      cur_col = 0;
    end else if (c == tcon_pkg::CHAR_BS) begin
      if (cur_col > 0) cur_col--;
      else begin
        cur_col = COLS - 1;
        if (cur_row > 0) cur_row--;
      end
    end else begin
      shadow_screen[cur_row * COLS + cur_col] = {shadow_colour, c};
      cur_col++;
      if (cur_col >= COLS) begin
        cur_col = 0; cur_row++;
      end
    end
    if (cur_row >= LINES) begin
      cur_row = LINES - 1; cur_col = 0;
      for (int i = 0; i < (LINES - 1) * COLS; i++)
        shadow_screen[i] = shadow_screen[i + COLS];
      blank_row(LINES - 1);
    end
  endfunction

  function automatic tcon_pkg::out_item_t console_step(input tcon_pkg::in_item_t it);
    tcon_pkg::out_item_t res;
    res = '0;
    if (it.mode == tcon_pkg::MODE_READ) begin
      if (it.cell_address < CELLS) begin
        res.cell_char      = shadow_screen[it.cell_address][7:0];
        res.cell_attribute = shadow_screen[it.cell_address][15:8];
      end
    end else if (parse_escape(it.char_code)) begin
      res.swallowed = 1'b1;
    end else begin
      print_byte(it.char_code);
    end
    res.cursor_position = POS_W'(cur_row * COLS + cur_col);
    return res;
  endfunction

  // Driver: present queued transactions with random gaps
  int drive_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(console_step(in_item));
        void'(pending_items.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (drive_gap > 0) begin
        drive_gap <= drive_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0
                   && !(in_valid && !in_stall && gap_len() != 0)) begin
        in_valid <= 1'b1;
        in_item  <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
        if (in_valid && !in_stall) drive_gap <= gap_len();
      end
    end
  end

  // Monitor: compare each result against the oldest prediction
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          errors++;
        end else begin
          tcon_pkg::out_item_t e;
          e = expected_results.pop_front();
          if (out_item.cell_char !== e.cell_char)
            $display("%0t: cell_char expected %h actual %h", $time, e.cell_char,
                     out_item.cell_char);
          if (out_item.cell_attribute !== e.cell_attribute)
            $display("%0t: cell_attribute expected %h actual %h", $time,
                     e.cell_attribute, out_item.cell_attribute);
          if (out_item.cursor_position !== e.cursor_position)
            $display("%0t: cursor_position expected %0d actual %0d", $time,
                     e.cursor_position, out_item.cursor_position);
          if (out_item.swallowed !== e.swallowed)
            $display("%0t: swallowed expected %b actual %b", $time, e.swallowed,
                     out_item.swallowed);
          if (out_item !== e) errors++;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left <= gap_len();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic tcon_pkg::in_item_t feed(input logic [7:0] c);
    tcon_pkg::in_item_t it;
    it = '0;
    it.mode = tcon_pkg::MODE_FEED;
    it.char_code = c;
    it.cell_address = POS_W'($urandom);
    return it;
  endfunction

  function automatic tcon_pkg::in_item_t peek(input logic [POS_W-1:0] a);
    tcon_pkg::in_item_t it;
    it = '0;
    it.mode = tcon_pkg::MODE_READ;
    it.cell_address = a;
    it.char_code = 8'($urandom);
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (CELLS + 20) @(posedge clk);
  endtask

  task automatic write_colour(input logic [7:0] v);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    shadow_colour = v;
  endtask

  task automatic add_escape(input logic [7:0] digit, input logic [7:0] fin);
    pending_items.push_back(feed(tcon_pkg::CHAR_ESC));
    pending_items.push_back(feed(tcon_pkg::CHAR_LBRACKET));
    pending_items.push_back(feed(digit));
    pending_items.push_back(feed(fin));
  endtask

  task automatic random_burst(input int n);
    int k;
    logic [7:0] fins [4];
    fins = '{tcon_pkg::CHAR_D, tcon_pkg::CHAR_C, tcon_pkg::CHAR_K, tcon_pkg::CHAR_J};
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          pending_items.push_back(feed(8'($urandom_range(8'h20, 8'h7e)))); k++;
        end
        3: begin
          pending_items.push_back(feed(8'($urandom))); k++;
        end
        4: begin
          pending_items.push_back(feed($urandom_range(0, 1) ? tcon_pkg::CHAR_NL
                                                             : tcon_pkg::CHAR_CR));
          k++;
        end
        5: begin
          pending_items.push_back(feed(tcon_pkg::CHAR_BS)); k++;
        end
        6: begin
          // J with 3 is a full sweep; keep it rare
          logic [7:0] f;
          f = fins[$urandom_range(0, 3)];
          if (f == tcon_pkg::CHAR_J && $urandom_range(0, 7) != 0) f = tcon_pkg::CHAR_K;
          add_escape(8'(tcon_pkg::CHAR_ZERO + $urandom_range(0, 9)), f); k += 4;
        end
        7: begin
          // broken sequences
          pending_items.push_back(feed(tcon_pkg::CHAR_ESC));
          pending_items.push_back(feed(8'($urandom))); k += 2;
        end
        default: begin
          pending_items.push_back(peek($urandom_range(0, 9) == 0
                                       ? POS_W'($urandom)
                                       : POS_W'($urandom_range(0, CELLS - 1))));
          k++;
        end
      endcase
    end
  endtask

  initial begin
    console_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // directed
    pending_items.push_back(peek('0));
    pending_items.push_back(feed(8'hff));
    pending_items.push_back(feed(8'h00));
    pending_items.push_back(feed(tcon_pkg::CHAR_BS));
    pending_items.push_back(feed(tcon_pkg::CHAR_BS));
    pending_items.push_back(feed(tcon_pkg::CHAR_BS));
    pending_items.push_back(feed(tcon_pkg::CHAR_NL));
    add_escape(8'h39, tcon_pkg::CHAR_C);
    add_escape(8'h39, tcon_pkg::CHAR_D);
    add_escape(tcon_pkg::CHAR_ZERO + 8'd2, tcon_pkg::CHAR_K);
    pending_items.push_back(feed(tcon_pkg::CHAR_ESC));
    pending_items.push_back(feed(8'h41));
    pending_items.push_back(feed(tcon_pkg::CHAR_LBRACKET));
    pending_items.push_back(peek(POS_W'(CELLS - 1)));
    pending_items.push_back(peek('1));
    wait_drained();
    write_colour(8'hff);
    for (int i = 0; i < LINES; i++) pending_items.push_back(feed(tcon_pkg::CHAR_NL));
    pending_items.push_back(feed(tcon_pkg::CHAR_CR));
    pending_items.push_back(peek(POS_W'(CELLS - COLS)));
    add_escape(tcon_pkg::CHAR_ZERO + 8'd3, tcon_pkg::CHAR_J);
    random_burst(300);
    wait_drained();
    write_colour(8'h00);
    random_burst(350);
    wait_drained();
    write_colour(8'($urandom));
    random_burst(350);
    wait_drained();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
